FILE: rtl/core/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the segment pool allocator
// Field widths, status codes, register indexes and the command that the
// controller broadcasts to the row of segment cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

    localparam int ACTION_W  = 1;
    localparam int REQ_W     = 17;
    localparam int OFFSET_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 17;

    // Widest cell index for the largest table the block supports.
    localparam int IDX_MAX_W = 10;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

    localparam logic [CFG_W-1:0] POOL_RESET = 17'd65536;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_INSERT,
        OP_DELETE,
        OP_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [IDX_MAX_W-1:0]   idx;
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/spa_req_if.sv
// ----------------------------------------------------------------------------
// spa_req_if: request channel of the segment pool allocator
// Carries one allocate or free word from a source to the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_req_if;
    logic                          valid;
    logic                          ready;
    logic [spa_pkg::ACTION_W-1:0]  action;
    logic [spa_pkg::REQ_W-1:0]     request_bytes;
    logic [spa_pkg::OFFSET_W-1:0]  free_offset;

    modport source (output valid, output action, output request_bytes,
                    output free_offset, input ready);
    modport sink   (input valid, input action, input request_bytes,
                    input free_offset, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/spa_rsp_if.sv
// ----------------------------------------------------------------------------
// spa_rsp_if: response channel of the segment pool allocator
// Carries one status word and the granted offset back to the requester.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spa_pkg::STATUS_W-1:0]  status;
    logic [spa_pkg::OFFSET_W-1:0]  granted_offset;

    modport source (output valid, output status, output granted_offset, input ready);
    modport sink   (input valid, input status, input granted_offset, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/spa_cell.sv
// ----------------------------------------------------------------------------
// spa_cell: one entry of the segment table
// Holds start, size and used mark, and takes a neighbour's entry or the
// broadcast entry as the controller's command says.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_cell #(
    parameter int IDX = 0,
    parameter int AW  = 16
) (
    input  wire logic                 i_clk,
    input  wire spa_pkg::t_cell_cmd   i_cmd,
    input  wire logic [AW-1:0]        i_bus_start,
    input  wire logic [AW:0]          i_bus_size,
    input  wire logic                 i_bus_used,
    input  wire logic [AW-1:0]        i_left_start,
    input  wire logic [AW:0]          i_left_size,
    input  wire logic                 i_left_used,
    input  wire logic [AW-1:0]        i_right_start,
    input  wire logic [AW:0]          i_right_size,
    input  wire logic                 i_right_used,
    output logic [AW-1:0]             o_start,
    output logic [AW:0]               o_size,
    output logic                      o_used
);

    localparam logic [spa_pkg::IDX_MAX_W-1:0] MY_IDX = spa_pkg::IDX_MAX_W'(IDX);

    logic [AW-1:0] r_start;
    logic [AW:0]   r_size;
    logic          r_used;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            spa_pkg::OP_ROTATE: begin
                r_start <= i_right_start;
                r_size  <= i_right_size;
                r_used  <= i_right_used;
            end
            spa_pkg::OP_INSERT: begin
                if (MY_IDX == i_cmd.idx) begin
                    r_start <= i_bus_start;
                    r_size  <= i_bus_size;
                    r_used  <= i_bus_used;
                end else if (MY_IDX > i_cmd.idx) begin
                    r_start <= i_left_start;
                    r_size  <= i_left_size;
                    r_used  <= i_left_used;
                end
            end
            spa_pkg::OP_DELETE: begin
                if (MY_IDX >= i_cmd.idx) begin
                    r_start <= i_right_start;
                    r_size  <= i_right_size;
                    r_used  <= i_right_used;
                end
            end
            spa_pkg::OP_WRITE: begin
                if (MY_IDX == i_cmd.idx) begin
                    r_start <= i_bus_start;
                    r_size  <= i_bus_size;
                    r_used  <= i_bus_used;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_used  = r_used;

endmodule

`default_nettype wire

FILE: rtl/core/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl: sequencer of the segment pool allocator
// Scans the rotating table at cell 0, decides the edit, issues the insert,
// write and delete commands and returns the response word.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ctrl #(
    parameter int N = 64,
    parameter int A = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    spa_req_if.sink                           i_req,
    spa_rsp_if.source                         o_rsp,
    input  wire logic                         i_cfg_we,
    input  wire logic [spa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [spa_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [A-1:0]                 i_head_start,
    input  wire logic [A:0]                   i_head_size,
    input  wire logic                         i_head_used,
    output spa_pkg::t_cell_cmd                o_cmd,
    output logic [A-1:0]                      o_bus_start,
    output logic [A:0]                        o_bus_size,
    output logic                              o_bus_used
);

    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int SW = A + 1;
    localparam int OW = (A > spa_pkg::OFFSET_W) ? A : spa_pkg::OFFSET_W;
    localparam int ZW = (SW > spa_pkg::REQ_W) ? SW : spa_pkg::REQ_W;
    localparam logic [ZW-1:0] LIMIT = ZW'(1) << A;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_INS, S_WR, S_DEL, S_OUT
    } t_state;

    function automatic logic [SW-1:0] clamp_pool(input logic [spa_pkg::CFG_W-1:0] v);
        logic [ZW-1:0] z;
        z = ZW'(v);
        if (z > LIMIT) begin
            z = LIMIT;
        end
        return SW'(z);
    endfunction

    t_state                        r_state;
    logic [CW-1:0]                 r_count;
    logic                          r_mode;
    logic [IW-1:0]                 r_step;
    logic [spa_pkg::ACTION_W-1:0]  r_action;
    logic [spa_pkg::REQ_W-1:0]     r_want;
    logic [spa_pkg::OFFSET_W-1:0]  r_where;
    logic                          r_found;
    logic [IW-1:0]                 r_pick;
    logic [A-1:0]                  r_pstart;
    logic [SW-1:0]                 r_psize;
    logic                          r_prev_used;
    logic [A-1:0]                  r_prev_start;
    logic [SW-1:0]                 r_prev_size;
    logic                          r_dl;
    logic                          r_dr;
    logic                          r_npend;
    logic [SW-1:0]                 r_nsize;
    logic [IW-1:0]                 r_ins_idx;
    logic [A-1:0]                  r_ins_start;
    logic [SW-1:0]                 r_ins_size;
    logic [IW-1:0]                 r_wr_idx;
    logic [A-1:0]                  r_wr_start;
    logic [SW-1:0]                 r_wr_size;
    logic                          r_wr_used;
    logic [1:0]                    r_del_n;
    logic [IW-1:0]                 r_del_idx;
    logic [spa_pkg::STATUS_W-1:0]  r_status;
    logic [spa_pkg::OFFSET_W-1:0]  r_off;
    logic                          r_ovalid;
    logic [spa_pkg::STATUS_W-1:0]  r_ostatus;
    logic [spa_pkg::OFFSET_W-1:0]  r_ooff;

    logic          head_valid;
    logic          head_fit;
    logic          head_match;
    logic [SW-1:0] pool_new;
    logic [SW-1:0] want_s;
    logic [SW-1:0] merged;

    assign head_valid = CW'(r_step) < r_count;
    assign head_fit   = head_valid && !i_head_used && (ZW'(i_head_size) >= ZW'(r_want))
                        && (!r_found || (r_mode && (i_head_size < r_psize)));
    assign head_match = head_valid && !r_found && (OW'(i_head_start) == OW'(r_where));
    assign pool_new   = clamp_pool(i_cfg_data);
    assign want_s     = SW'(r_want);
    assign merged     = r_psize + (r_dl ? r_prev_size : '0) + (r_dr ? r_nsize : '0);

    // Command broadcast to the row of cells.
    always_comb begin
        o_cmd.op    = spa_pkg::OP_HOLD;
        o_cmd.idx   = '0;
        o_bus_start = r_wr_start;
        o_bus_size  = r_wr_size;
        o_bus_used  = r_wr_used;
        if (!i_rst_n) begin
            o_cmd.op    = spa_pkg::OP_WRITE;
            o_bus_start = '0;
            o_bus_size  = clamp_pool(spa_pkg::POOL_RESET);
            o_bus_used  = 1'b0;
        end else if (i_cfg_we && (i_cfg_idx == spa_pkg::CFG_POOL_BYTES)) begin
            o_cmd.op    = spa_pkg::OP_WRITE;
            o_bus_start = '0;
            o_bus_size  = pool_new;
            o_bus_used  = 1'b0;
        end else begin
            case (r_state)
                S_SCAN: o_cmd.op = spa_pkg::OP_ROTATE;
                S_INS: begin
                    o_cmd.op    = spa_pkg::OP_INSERT;
                    o_cmd.idx   = spa_pkg::IDX_MAX_W'(r_ins_idx);
                    o_bus_start = r_ins_start;
                    o_bus_size  = r_ins_size;
                    o_bus_used  = 1'b0;
                end
                S_WR: begin
                    o_cmd.op  = spa_pkg::OP_WRITE;
                    o_cmd.idx = spa_pkg::IDX_MAX_W'(r_wr_idx);
                end
                S_DEL: begin
                    o_cmd.op  = spa_pkg::OP_DELETE;
                    o_cmd.idx = spa_pkg::IDX_MAX_W'(r_del_idx);
                end
                default: o_cmd.op = spa_pkg::OP_HOLD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= (clamp_pool(spa_pkg::POOL_RESET) == '0) ? CW'(0) : CW'(1);
            r_mode   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == spa_pkg::CFG_POOL_BYTES) begin
                    r_count <= (pool_new == '0) ? CW'(0) : CW'(1);
                end else begin
                    r_mode <= i_cfg_data[0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_action <= i_req.action;
                        r_want   <= i_req.request_bytes;
                        r_where  <= i_req.free_offset;
                        r_step   <= '0;
                        r_found  <= 1'b0;
                        r_dl     <= 1'b0;
                        r_dr     <= 1'b0;
                        r_npend  <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_action == spa_pkg::ACT_ALLOC) begin
                        if (head_fit) begin
                            r_found  <= 1'b1;
                            r_pick   <= r_step;
                            r_pstart <= i_head_start;
                            r_psize  <= i_head_size;
                        end
                    end else begin
                        if (head_match) begin
                            r_found  <= 1'b1;
                            r_pick   <= r_step;
                            r_pstart <= i_head_start;
                            r_psize  <= i_head_size;
                            r_dl     <= (r_step != '0) && !r_prev_used;
                            r_npend  <= 1'b1;
                        end
                        if (r_npend) begin
                            r_npend <= 1'b0;
                            r_dr    <= head_valid && !i_head_used;
                            r_nsize <= i_head_size;
                        end
                    end
                    // The predecessor is frozen once the matching entry has passed.
                    if (!r_found && !head_match) begin
                        r_prev_used  <= i_head_used;
                        r_prev_start <= i_head_start;
                        r_prev_size  <= i_head_size;
                    end
                    r_step       <= r_step + IW'(1);
                    if (r_step == IW'(N - 1)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_del_n  <= 2'd0;
                    r_off    <= '0;
                    r_state  <= S_OUT;
                    if (r_action == spa_pkg::ACT_ALLOC) begin
                        if ((r_want == '0) || !r_found) begin
                            r_status <= spa_pkg::ST_NOMEM;
                        end else if (ZW'(r_psize) > ZW'(r_want)) begin
                            if (r_count == CW'(N)) begin
                                r_status <= spa_pkg::ST_FULL;
                            end else begin
                                r_status    <= spa_pkg::ST_OK;
                                r_off       <= spa_pkg::OFFSET_W'(OW'(r_pstart));
                                r_ins_idx   <= r_pick + IW'(1);
                                r_ins_start <= r_pstart + A'(want_s);
                                r_ins_size  <= r_psize - want_s;
                                r_wr_idx    <= r_pick;
                                r_wr_start  <= r_pstart;
                                r_wr_size   <= want_s;
                                r_wr_used   <= 1'b1;
                                r_count     <= r_count + CW'(1);
                                r_state     <= S_INS;
                            end
                        end else begin
                            r_status   <= spa_pkg::ST_OK;
                            r_off      <= spa_pkg::OFFSET_W'(OW'(r_pstart));
                            r_wr_idx   <= r_pick;
                            r_wr_start <= r_pstart;
                            r_wr_size  <= r_psize;
                            r_wr_used  <= 1'b1;
                            r_state    <= S_WR;
                        end
                    end else begin
                        if (!r_found) begin
                            r_status <= spa_pkg::ST_NOTFOUND;
                        end else begin
                            // The merged segment lands on the predecessor when that
                            // one is free, and the absorbed entries are then removed.
                            r_status   <= spa_pkg::ST_OK;
                            r_wr_idx   <= r_dl ? (r_pick - IW'(1)) : r_pick;
                            r_wr_start <= r_dl ? r_prev_start : r_pstart;
                            r_wr_size  <= merged;
                            r_wr_used  <= 1'b0;
                            r_del_n    <= {1'b0, r_dl} + {1'b0, r_dr};
                            r_del_idx  <= r_dl ? r_pick : (r_pick + IW'(1));
                            r_count    <= r_count - CW'({1'b0, r_dl}) - CW'({1'b0, r_dr});
                            r_state    <= S_WR;
                        end
                    end
                end
                S_INS: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= (r_del_n != 2'd0) ? S_DEL : S_OUT;
                end
                S_DEL: begin
                    r_del_n <= r_del_n - 2'd1;
                    if (r_del_n == 2'd1) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_ooff    <= r_off;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_ostatus;
    assign o_rsp.granted_offset = r_ooff;

endmodule

`default_nettype wire

FILE: rtl/core/segment_pool_allocator.sv
// ----------------------------------------------------------------------------
// segment_pool_allocator: byte pool allocator over an ordered segment table
// A row of segment cells with a sequencer that serves allocate and free words.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on i_req as valid/ready words: action 0 asks for
// request_bytes with first fit or best fit as fit_mode selects, action 1 frees
// the segment starting at free_offset and merges it with free neighbours.
// Each request gives exactly one word on o_rsp with a status and, for a
// successful allocation, the granted offset.
// The table lives in MAX_SEGMENTS cells in a ring. A request rotates the ring
// once past cell 0, where the sequencer inspects every entry; a word then goes
// from acceptance to the response register through the scan, a decision step,
// up to three shift or write commands to the row and the loading of the
// response. One request is in work at a time; i_req.ready is high only while
// the sequencer is idle, so a new request is taken only once the last one has
// loaded its response.
// A response waiting on a stalled receiver is held in the output register;
// the next request is still accepted and its result waits until that word
// has gone.
// Reset (synchronous, active low) and a write of pool_bytes both rebuild the
// table at once as one free segment of the pool size, clamped to the address
// range; fit_mode resets to first fit. Configuration writes take effect in
// the cycle they are made and are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_pool_allocator #(
    parameter int MAX_SEGMENTS   = 64,
    parameter int POOL_ADDR_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    spa_req_if.sink                            i_req,
    spa_rsp_if.source                          o_rsp,
    input  wire logic                          i_cfg_we,
    input  wire logic [spa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [spa_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int N = MAX_SEGMENTS;
    localparam int A = POOL_ADDR_BITS;

    // Cell outputs, one per entry; each cell reads only its two neighbours.
    logic [A-1:0] w_start [N];
    logic [A:0]   w_size  [N];
    logic         w_used  [N];

    spa_pkg::t_cell_cmd w_cmd;
    logic [A-1:0]       w_bus_start;
    logic [A:0]         w_bus_size;
    logic               w_bus_used;

    spa_ctrl #(
        .N (N),
        .A (A)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head_start (w_start[0]),
        .i_head_size  (w_size[0]),
        .i_head_used  (w_used[0]),
        .o_cmd        (w_cmd),
        .o_bus_start  (w_bus_start),
        .o_bus_size   (w_bus_size),
        .o_bus_used   (w_bus_used)
    );

    // The row closes into a ring so that a scan returns every entry to its
    // own cell after exactly one revolution.
    for (genvar j = 0; j < N; j++) begin : g_cell
        localparam int LEFT  = (j == 0) ? (N - 1) : (j - 1);
        localparam int RIGHT = (j == N - 1) ? 0 : (j + 1);

        spa_cell #(
            .IDX (j),
            .AW  (A)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_bus_start   (w_bus_start),
            .i_bus_size    (w_bus_size),
            .i_bus_used    (w_bus_used),
            .i_left_start  (w_start[LEFT]),
            .i_left_size   (w_size[LEFT]),
            .i_left_used   (w_used[LEFT]),
            .i_right_start (w_start[RIGHT]),
            .i_right_size  (w_size[RIGHT]),
            .i_right_used  (w_used[RIGHT]),
            .o_start       (w_start[j]),
            .o_size        (w_size[j]),
            .o_used        (w_used[j])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/core/spa_checker.sv
// ----------------------------------------------------------------------------
// spa_checker: port-level checks for the segment pool allocator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [spa_pkg::STATUS_W-1:0]  i_out_status,
    input  wire logic [spa_pkg::OFFSET_W-1:0]  i_out_offset
);

    // A held response keeps its word until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_offset))
        else $error("response changed while stalled");

    // A failed request never carries an offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != spa_pkg::ST_OK) |-> (i_out_offset == '0))
        else $error("failed response carries an offset");

    // Only one request is in work: acceptance closes the request channel.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while another is in work");

    // A request's response needs the table scan, so none appears next cycle.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("response appeared without a table scan");

endmodule

bind segment_pool_allocator spa_checker u_spa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_offset (o_rsp.granted_offset)
);

`default_nettype wire

FILE: tb/tb_segment_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_segment_pool_allocator: self-checking bench of the segment pool allocator
// Drives allocate and free words with random idling on both channels, keeps
// its own segment table to forecast every response word and compares each
// response with the oldest forecast.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_pool_allocator;

    localparam int NSEG = 64;
    localparam int ADDR_BITS = 16;
    // Latency of one word through the block, with margin.
    localparam int DRAIN_CYCLES = NSEG + 20;

    typedef struct packed {
        logic [spa_pkg::STATUS_W-1:0] status;
        logic [spa_pkg::OFFSET_W-1:0] offset;
    } t_rsp_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [spa_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [spa_pkg::CFG_W-1:0] i_cfg_data = '0;

    spa_req_if req_ch ();
    spa_rsp_if rsp_ch ();

    segment_pool_allocator #(
        .MAX_SEGMENTS   (NSEG),
        .POOL_ADDR_BITS (ADDR_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The bench's own copy of the segment table.
    logic [16:0] tbl_start [NSEG];
    logic [16:0] tbl_size [NSEG];
    logic        tbl_used [NSEG];
    int          tbl_count;
    logic        best_fit;

    t_rsp_word pending_rsp [$];
    int  fail_count = 0;
    bit  idle_enabled = 1'b1;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = spa_pkg::ACT_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.free_offset = '0;
        rsp_ch.ready = 1'b0;
    end

    // Rebuilds the table as one free segment, as reset and a pool write do.
    function automatic void pool_rebuild(logic [16:0] bytes);
        logic [17:0] clamped;
        clamped = (bytes > 17'd65536) ? 18'd65536 : {1'b0, bytes};
        for (int k = 0; k < NSEG; k++) begin
            tbl_start[k] = '0;
            tbl_size[k] = '0;
            tbl_used[k] = 1'b0;
        end
        tbl_size[0] = clamped[16:0];
        tbl_count = (clamped == 0) ? 0 : 1;
    endfunction

    function automatic void drop_segment(int k);
        for (int j = k; j + 1 < tbl_count; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_size[j] = tbl_size[j+1];
            tbl_used[j] = tbl_used[j+1];
        end
        tbl_count--;
    endfunction

    function automatic t_rsp_word grant_bytes(logic [16:0] want);
        t_rsp_word w;
        int pick;
        bit found;
        w = '{status: spa_pkg::ST_NOMEM, offset: '0};
        pick = 0;
        found = 1'b0;
        if (want == 0) return w;
        for (int k = 0; k < tbl_count; k++) begin
            if (tbl_used[k] || tbl_size[k] < want) continue;
            if (!found || (best_fit && tbl_size[k] < tbl_size[pick])) begin
                pick = k;
                found = 1'b1;
                if (!best_fit) break;
            end
        end
        if (!found) return w;
        if (tbl_size[pick] > want) begin
            if (tbl_count >= NSEG) begin
                w.status = spa_pkg::ST_FULL;
                return w;
            end
            for (int j = tbl_count; j > pick + 1; j--) begin
                tbl_start[j] = tbl_start[j-1];
                tbl_size[j] = tbl_size[j-1];
                tbl_used[j] = tbl_used[j-1];
            end
            tbl_start[pick+1] = tbl_start[pick] + want;
            tbl_size[pick+1] = tbl_size[pick] - want;
            tbl_used[pick+1] = 1'b0;
            tbl_count++;
            tbl_size[pick] = want;
        end
        tbl_used[pick] = 1'b1;
        w.status = spa_pkg::ST_OK;
        w.offset = tbl_start[pick][15:0];
        return w;
    endfunction

    function automatic t_rsp_word release_offset(logic [15:0] where);
        t_rsp_word w;
        int k;
        w = '{status: spa_pkg::ST_NOTFOUND, offset: '0};
        for (k = 0; k < tbl_count; k++)
            if (tbl_start[k] == {1'b0, where}) break;
        if (k >= tbl_count) return w;
        tbl_used[k] = 1'b0;
        if (k > 0 && !tbl_used[k-1]) begin
            tbl_size[k-1] += tbl_size[k];
            drop_segment(k);
            k--;
        end
        if (k + 1 < tbl_count && !tbl_used[k+1]) begin
            tbl_size[k] += tbl_size[k+1];
            drop_segment(k + 1);
        end
        w.status = spa_pkg::ST_OK;
        return w;
    endfunction

    task automatic idle_burst();
        int gap;
        if (idle_enabled && $urandom_range(3) == 0) begin
            gap = $urandom_range(11, 1);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one request word and files its forecast once it is accepted.
    task automatic send_word(logic [spa_pkg::ACTION_W-1:0] act, logic [16:0] bytes,
                             logic [15:0] where);
        t_rsp_word fc;
        idle_burst();
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.request_bytes <= bytes;
        req_ch.free_offset <= where;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (act == spa_pkg::ACT_ALLOC) fc = grant_bytes(bytes);
        else fc = release_offset(where);
        pending_rsp = {pending_rsp, fc};
        req_ch.valid <= 1'b0;
        // The block is busy with the scan, so this low cycle costs nothing.
        @(posedge i_clk);
    endtask

    task automatic alloc(logic [16:0] bytes);
        send_word(spa_pkg::ACT_ALLOC, bytes, 16'($urandom));
    endtask

    task automatic release_at(logic [15:0] where);
        send_word(spa_pkg::ACT_FREE, 17'($urandom), where);
    endtask

    // Waits for every forecast to be met, then lets the block settle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [spa_pkg::CFG_IDX_W-1:0] idx, logic [16:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == spa_pkg::CFG_POOL_BYTES) pool_rebuild(val);
        else best_fit = val[0];
    endtask

    // Offset of a random segment start, used or not; now and then a random one.
    function automatic logic [15:0] pick_offset();
        if (tbl_count == 0 || $urandom_range(7) == 0) return 16'($urandom);
        return tbl_start[$urandom_range(tbl_count - 1)][15:0];
    endfunction

    function automatic logic [15:0] pick_used_offset();
        int k;
        for (int n = 0; n < 8; n++) begin
            if (tbl_count == 0) break;
            k = $urandom_range(tbl_count - 1);
            if (tbl_used[k]) return tbl_start[k][15:0];
        end
        return pick_offset();
    endfunction

    // Response checker: the receiver stalls in bursts while idling is on.
    always @(posedge i_clk) begin
        t_rsp_word want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected response word status=%0d", rsp_ch.status);
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.granted_offset !== want.offset) begin
                    $error("granted_offset: expected %0d, got %0d",
                           want.offset, rsp_ch.granted_offset);
                    fail_count++;
                end
            end
        end
    end

    initial begin : rsp_stall
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (idle_enabled && $urandom_range(4) == 0) begin
                rsp_ch.ready <= 1'b0;
                gap = $urandom_range(11, 1);
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Field extremes, exact fits, zero-byte and oversized requests,
    // unknown and already-free offsets.
    task automatic test_directed();
        alloc(17'd0);
        alloc(17'd65536);
        alloc(17'd1);
        release_at(16'd0);
        release_at(16'd0);
        release_at(16'hFFFF);
        alloc(17'd1);
        alloc(17'd65535);
        alloc(17'd1);
        release_at(16'd1);
        release_at(16'd0);
        alloc(17'd100);
        alloc(17'h1FFFF);
    endtask

    task automatic test_fit_modes();
        write_reg(spa_pkg::CFG_POOL_BYTES, 17'd1000);
        write_reg(spa_pkg::CFG_FIT_MODE, 17'd1);
        alloc(17'd300);
        alloc(17'd10);
        alloc(17'd100);
        alloc(17'd10);
        release_at(16'd0);
        release_at(16'd310);
        alloc(17'd50);
        write_reg(spa_pkg::CFG_FIT_MODE, 17'd0);
        alloc(17'd50);
    endtask

    // Small pools, the empty pool, the clamped pool and a full table.
    task automatic test_pool_sizes();
        write_reg(spa_pkg::CFG_POOL_BYTES, 17'd0);
        alloc(17'd1);
        release_at(16'd0);
        write_reg(spa_pkg::CFG_POOL_BYTES, 17'h1FFFF);
        alloc(17'd65536);
        write_reg(spa_pkg::CFG_POOL_BYTES, 17'd1);
        alloc(17'd1);
        alloc(17'd1);
        write_reg(spa_pkg::CFG_POOL_BYTES, 17'd200);
        repeat (NSEG + 2) alloc(17'd1);
        alloc(17'($urandom_range(136, 137)));
        release_at(16'd5);
        alloc(17'd1);
    endtask

    task automatic test_random(int count, int pool_bytes, bit bursty);
        int r;
        write_reg(spa_pkg::CFG_POOL_BYTES, 17'(pool_bytes));
        write_reg(spa_pkg::CFG_FIT_MODE, 17'($urandom_range(1)));
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                if (bursty && $urandom_range(9) == 0) alloc(17'($urandom));
                else alloc(17'($urandom_range(pool_bytes / 8 + 1, 0)));
            end else if (r < 90) release_at(pick_used_offset());
            else release_at(pick_offset());
        end
    endtask

    initial begin
        best_fit = 1'b0;
        pool_rebuild(spa_pkg::POOL_RESET);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fit_modes();
        test_pool_sizes();
        test_random(300, 65536, 1'b1);
        test_random(300, 500, 1'b1);
        // The sender holds off until every forecast has been met.
        wait_drained();
        test_random(300, 4096, 1'b1);
        idle_enabled = 1'b0;
        test_random(200, 300, 1'b0);
        wait_drained();
        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("tb_segment_pool_allocator: clean");
        end else begin
            $display("tb_segment_pool_allocator: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("tb_segment_pool_allocator: errors");
        $finish;
    end
endmodule

`default_nettype wire
